### design/acld_pkg.sv
// ----------------------------------------------------------------------------
// acld_pkg: shared types and constants
// Types and constants shared by the lower-bound distance engine and its
// submodules.
// ----------------------------------------------------------------------------
`default_nettype none

package acld_pkg;

  localparam int DEF_MAX_DIMS  = 16;
  localparam int DEF_MAX_CELLS = 256;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TERM = 1'b1;

  localparam logic REG_SERIES_LENGTH = 1'b0;

  localparam logic [16:0] SERIES_LENGTH_RESET = 17'd256;

  localparam int DIV_STEPS = 64;

  typedef struct packed {
    logic        valid;
    logic        last;
    logic        live;
    logic        above;
    logic [31:0] qcoef;
  } issue_t;

  typedef struct packed {
    logic        valid;
    logic        last;
    logic [63:0] term;
  } term_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

endpackage

`default_nettype wire

### design/acld_store.sv
// ----------------------------------------------------------------------------
// acld_store: boundary memory
// Single-port-write, single-port-read synchronous memory holding the cell
// boundaries of every dimension. Read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module acld_store #(
  parameter int DEPTH = 4112,
  parameter int AW    = 13
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### design/acld_term.sv
// ----------------------------------------------------------------------------
// acld_term: distance term pipeline
// Forms the gap from the boundary read, squares its magnitude and doubles the
// square with saturation, over three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module acld_term (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire acld_pkg::issue_t issue,
  input  wire logic [31:0]     rdata,
  output acld_pkg::term_t      result,
  output logic                 last_busy
);

  import acld_pkg::*;

  issue_t      s1;
  logic        s2_valid;
  logic        s2_last;
  logic [31:0] s2_mag;
  logic        s3_valid;
  logic        s3_last;
  logic [63:0] s3_sq;

  logic signed [32:0] gap;
  logic        [32:0] mag_wide;
  logic        [31:0] mag;

  always_comb begin
    if (s1.above) begin
      gap = {rdata[31], rdata} - {s1.qcoef[31], s1.qcoef};
    end else begin
      gap = {s1.qcoef[31], s1.qcoef} - {rdata[31], rdata};
    end
    mag_wide = gap[32] ? (33'd0 - gap) : gap;
    mag = s1.live ? mag_wide[31:0] : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1.valid <= issue.valid;
      s2_valid <= s1.valid;
      s3_valid <= s2_valid;
    end
    s1.last  <= issue.last;
    s1.live  <= issue.live;
    s1.above <= issue.above;
    s1.qcoef <= issue.qcoef;
    s2_last  <= s1.last;
    s2_mag   <= mag;
    s3_last  <= s2_last;
    s3_sq    <= 64'(s2_mag) * 64'(s2_mag);
  end

  always_comb begin
    result.valid = s3_valid;
    result.last  = s3_last;
    result.term  = s3_sq[63] ? {64{1'b1}} : {s3_sq[62:0], 1'b0};
    last_busy    = (s1.valid && s1.last) || (s2_valid && s2_last) ||
                   (s3_valid && s3_last);
  end

endmodule

`default_nettype wire

### design/acld_div.sv
// ----------------------------------------------------------------------------
// acld_div: sequential divider
// Restoring divider that retires one quotient bit per cycle and saturates the
// quotient to 63 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module acld_div (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [63:0]   dividend,
  input  wire logic [16:0]   divisor,
  input  wire logic          take,
  output acld_pkg::div_stat_t stat,
  output logic      [62:0]   quotient
);

  import acld_pkg::*;

  localparam int CW = $clog2(DIV_STEPS);

  div_state_t    state;
  div_state_t    state_next;
  logic [63:0]   dvd;
  logic [16:0]   rem;
  logic [16:0]   dsr;
  logic [CW-1:0] count;

  logic [17:0] trial;
  logic [18:0] diff;
  logic        ge;
  logic        final_step;

  always_comb begin
    trial      = {rem, dvd[63]};
    diff       = {1'b0, trial} - {2'b00, dsr};
    ge         = !diff[18];
    final_step = (count == CW'(DIV_STEPS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      DIV_IDLE: begin
        if (start) begin
          state_next = DIV_RUN;
        end
      end
      DIV_RUN: begin
        if (final_step) begin
          state_next = DIV_DONE;
        end
      end
      DIV_DONE: begin
        if (take) begin
          state_next = DIV_IDLE;
        end
      end
      default: state_next = DIV_IDLE;
    endcase
  end

  always_comb begin
    stat.busy = (state != DIV_IDLE);
    stat.done = (state == DIV_DONE);
    quotient  = dvd[63] ? {63{1'b1}} : dvd[62:0];
  end

  always_ff @(posedge clk) begin
    if (state == DIV_IDLE && start) begin
      dvd   <= dividend;
      rem   <= 17'd0;
      dsr   <= (divisor == 17'd0) ? 17'd1 : divisor;
      count <= '0;
    end else if (state == DIV_RUN) begin
      dvd   <= {dvd[62:0], ge};
      rem   <= ge ? diff[16:0] : trial[16:0];
      count <= count + CW'(1);
    end
  end

endmodule

`default_nettype wire

### design/approx_cell_lower_bound_distance.sv
// ----------------------------------------------------------------------------
// approx_cell_lower_bound_distance: cell lower-bound distance engine
// Stores per-dimension cell boundaries and accumulates the lower-bound
// squared distance of a candidate cell against a query.
// ----------------------------------------------------------------------------
// Load and term items are taken one per cycle while no final term is in
// flight. A term reads at most one boundary from the memory, then passes a gap
// stage and a squaring stage before it reaches the accumulator. A final term
// starts a bit-serial division of the sum by series_length; the next item is
// taken once the quotient has moved into the output register. The result
// stays in the output register until its transfer, while new items are taken.
`default_nettype none

module approx_cell_lower_bound_distance #(
  parameter int MAX_DIMS  = acld_pkg::DEF_MAX_DIMS,
  parameter int MAX_CELLS = acld_pkg::DEF_MAX_CELLS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               op,
  input  wire logic [3:0]         dimension,
  input  wire logic [8:0]         cell_index,
  input  wire logic [7:0]         query_cell,
  input  wire logic signed [31:0] query_coef,
  input  wire logic signed [31:0] boundary_value,
  input  wire logic               last_term,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [62:0]        distance
);

  import acld_pkg::*;

  localparam int ROW   = MAX_CELLS + 1;
  localparam int DEPTH = MAX_DIMS * ROW;
  localparam int AW    = $clog2(DEPTH);

  logic [16:0] series_length;
  logic [63:0] run_sum;

  logic          accept;
  logic          dim_ok;
  logic          cell_ok;
  logic          above;
  logic          differ;
  logic [31:0]   idx_raw;
  logic [31:0]   idx;
  logic [31:0]   row_base;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic          we;
  logic          re;
  logic [31:0]   rdata;
  issue_t        issue;
  term_t         term;
  logic          last_busy;

  logic [64:0]   sum_wide;
  logic [63:0]   sum_add;
  logic          div_start;
  logic          div_take;
  div_stat_t     div_stat;
  logic [62:0]   quotient;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SERIES_LENGTH) ? 32'(series_length) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      series_length <= SERIES_LENGTH_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_SERIES_LENGTH) begin
      series_length <= pwdata[16:0];
    end
  end

  assign in_ready = !div_stat.busy && !last_busy;
  assign accept   = in_valid && in_ready;

  always_comb begin
    dim_ok   = 32'(dimension) < 32'(MAX_DIMS);
    cell_ok  = 32'(cell_index) <= 32'(MAX_CELLS);
    above    = cell_index > {1'b0, query_cell};
    differ   = cell_index != {1'b0, query_cell};
    idx_raw  = 32'(cell_index) + (above ? 32'd0 : 32'd1);
    idx      = (idx_raw > 32'(MAX_CELLS)) ? 32'(MAX_CELLS) : idx_raw;
    row_base = 32'(dimension) * 32'(ROW);
    raddr    = AW'(row_base + idx);
    waddr    = AW'(row_base + 32'(cell_index));
    we       = accept && op == OP_LOAD && dim_ok && cell_ok;
    re       = accept && op == OP_TERM && dim_ok && differ;

    issue.valid = accept && op == OP_TERM;
    issue.last  = last_term;
    issue.live  = dim_ok && differ;
    issue.above = above;
    issue.qcoef = query_coef;
  end

  acld_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(boundary_value),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  acld_term u_term (
    .clk      (clk),
    .rst      (rst),
    .issue    (issue),
    .rdata    (rdata),
    .result   (term),
    .last_busy(last_busy)
  );

  always_comb begin
    sum_wide  = {1'b0, run_sum} + {1'b0, term.term};
    sum_add   = sum_wide[64] ? {64{1'b1}} : sum_wide[63:0];
    div_start = term.valid && term.last;
    div_take  = div_stat.done && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_sum <= 64'd0;
    end else if (term.valid) begin
      run_sum <= term.last ? 64'd0 : sum_add;
    end
  end

  acld_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(sum_add),
    .divisor (series_length),
    .take    (div_take),
    .stat    (div_stat),
    .quotient(quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (div_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_take) begin
      distance <= quotient;
    end
  end

  a_div_idle_at_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("final term reached a busy divider");

  a_sum_cleared: assert property (@(posedge clk) disable iff (rst)
    div_start |=> run_sum == 64'd0)
    else $error("running sum not cleared after final term");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    div_take |=> out_valid && !div_stat.done)
    else $error("quotient handoff to output register failed");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    div_stat.done && out_valid && !out_ready |=> div_stat.done)
    else $error("quotient dropped while output register was full");

endmodule

`default_nettype wire
